### hdl/dwff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwff_pkg
// Shared constants, types and helper functions of the dirty window frame
// flusher: sizes, request codes, stream program and color conversion.
// ----------------------------------------------------------------------------
package dwff_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 160;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  // row * width + col with 8-bit operands, plus one bit to see past the store
  localparam int PROD_W     = 17;
  localparam int CFG_IDX_W  = 3;

  // request codes
  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_FLUSH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_CODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_CODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_CODE      = 3'd4;

  // stream steps
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_COL_CMD = 4'd1;
  localparam logic [3:0] PH_COL_B0  = 4'd2;
  localparam logic [3:0] PH_COL_B1  = 4'd3;
  localparam logic [3:0] PH_COL_B2  = 4'd4;
  localparam logic [3:0] PH_COL_B3  = 4'd5;
  localparam logic [3:0] PH_ROW_CMD = 4'd6;
  localparam logic [3:0] PH_ROW_B0  = 4'd7;
  localparam logic [3:0] PH_ROW_B1  = 4'd8;
  localparam logic [3:0] PH_ROW_B2  = 4'd9;
  localparam logic [3:0] PH_ROW_B3  = 4'd10;
  localparam logic [3:0] PH_MEM_CMD = 4'd11;
  localparam logic [3:0] PH_PIXELS  = 4'd12;

  // byte sources of the output mux
  localparam logic [3:0] SRC_ZERO    = 4'd0;
  localparam logic [3:0] SRC_X0      = 4'd1;
  localparam logic [3:0] SRC_X1      = 4'd2;
  localparam logic [3:0] SRC_Y0      = 4'd3;
  localparam logic [3:0] SRC_Y1      = 4'd4;
  localparam logic [3:0] SRC_COL_CMD = 4'd5;
  localparam logic [3:0] SRC_ROW_CMD = 4'd6;
  localparam logic [3:0] SRC_MEM_CMD = 4'd7;
  localparam logic [3:0] SRC_PIXEL   = 4'd8;

  typedef struct packed {
    logic       is_data;
    logic [3:0] src;
    logic       pixel_step;  // conditional jump on the pixel walk
    logic [3:0] next_step;
  } ucode_t;

  // stream program, one control word per step
  function automatic ucode_t ucode_rom(input logic [3:0] step);
    ucode_t w;
    case (step)
      PH_COL_CMD: w = '{1'b0, SRC_COL_CMD, 1'b0, PH_COL_B0};
      PH_COL_B0:  w = '{1'b1, SRC_ZERO,    1'b0, PH_COL_B1};
      PH_COL_B1:  w = '{1'b1, SRC_X0,      1'b0, PH_COL_B2};
      PH_COL_B2:  w = '{1'b1, SRC_ZERO,    1'b0, PH_COL_B3};
      PH_COL_B3:  w = '{1'b1, SRC_X1,      1'b0, PH_ROW_CMD};
      PH_ROW_CMD: w = '{1'b0, SRC_ROW_CMD, 1'b0, PH_ROW_B0};
      PH_ROW_B0:  w = '{1'b1, SRC_ZERO,    1'b0, PH_ROW_B1};
      PH_ROW_B1:  w = '{1'b1, SRC_Y0,      1'b0, PH_ROW_B2};
      PH_ROW_B2:  w = '{1'b1, SRC_ZERO,    1'b0, PH_ROW_B3};
      PH_ROW_B3:  w = '{1'b1, SRC_Y1,      1'b0, PH_MEM_CMD};
      PH_MEM_CMD: w = '{1'b0, SRC_MEM_CMD, 1'b0, PH_PIXELS};
      PH_PIXELS:  w = '{1'b1, SRC_PIXEL,   1'b1, PH_PIXELS};
      default:    w = '{1'b1, SRC_ZERO,    1'b0, PH_IDLE};
    endcase
    return w;
  endfunction

  // rgb565 to 3-3-2: red / 4, green / 9, blue / 10 by reciprocal multiply
  function automatic logic [7:0] to_332(input logic [15:0] c);
    logic [4:0]  r;
    logic [5:0]  g;
    logic [4:0]  b;
    logic [11:0] g_m;
    logic [8:0]  b_m;
    r   = c[15:11];
    g   = c[10:5];
    b   = c[4:0];
    g_m = 12'(g) * 12'd57;   // floor(g / 9) == (g * 57) >> 9 for g < 64
    b_m = 9'(b) * 9'd13;     // floor(b / 10) == (b * 13) >> 7 for b < 32
    return {r[4:2], g_m[11:9], b_m[8:7]};
  endfunction

  // 3-3-2 back to rgb565: red * 4, green * 9, blue * 10
  function automatic logic [15:0] to_565(input logic [7:0] v);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = {v[7:5], 2'b00};
    g = 6'(v[4:2]) * 6'd9;
    b = 5'(v[1:0]) * 5'd10;
    return {r, g, b};
  endfunction

endpackage

### hdl/dirty_window_frame_flusher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_window_frame_flusher
// Frame store with dirty bounding box; streams panel window and pixel bytes.
// ----------------------------------------------------------------------------
// usage
//   in_*  : requests (draw, flush, clear, tick) on valid/ready.
//   out_* : one byte per tick while a stream runs (command or data, last flag).
//   cfg_* : plain register writes, taken at any cycle, only while idle in use.
// timing
//   one request at a time; in_ready is high only while the control is idle.
//   draw: accept, then store write. flush: accept only.
//   tick with a command/address byte or a clear pixel: accept, then emit.
//   tick with a flush pixel: accept with address multiply, store read, emit,
//   with the read on the single registered read port of the frame store.
//   clear: accept, then a wipe of the frame store, one entry per cycle.
// reset
//   after reset all STORE_SIZE entries of the store (20480 at the default
//   size) are wiped with in_ready low; a clear request runs the same wipe.
// stalls
//   the result sits in an output register; the next request is still taken,
//   and a following tick waits in its emit step until that register frees.
// ----------------------------------------------------------------------------
module dirty_window_frame_flusher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic signed [15:0]              in_pos_x,
  input  logic signed [15:0]              in_pos_y,
  input  logic [15:0]                     in_colour,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_is_data,
  output logic [7:0]                      out_byte_value,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [dwff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_wdata
);

  import dwff_pkg::*;

  localparam logic [2:0] ST_WIPE = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DRAW = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] wipe_addr_r, wipe_addr_nxt;

  logic [7:0] screen_width_r, screen_height_r;
  logic [7:0] col_code_r, row_code_r, mem_code_r;

  logic [7:0] box_left_r, box_left_nxt, box_top_r, box_top_nxt;
  logic [7:0] box_right_r, box_right_nxt, box_bottom_r, box_bottom_nxt;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  walk_row_r, walk_row_nxt, walk_col_r, walk_col_nxt;
  logic        low_r, low_nxt;
  logic        clearing_r, clearing_nxt;
  logic [15:0] fill_r, fill_nxt;
  logic [7:0]  win_x0_r, win_x0_nxt, win_y0_r, win_y0_nxt;
  logic [7:0]  win_x1_r, win_x1_nxt, win_y1_r, win_y1_nxt;

  logic [ADDR_W-1:0] draw_addr_r, draw_addr_nxt;
  logic [7:0]        draw_data_r, draw_data_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_is_data_r, out_is_data_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic [7:0]        eff_w, eff_h;
  logic [15:0]       pos_x_u, pos_y_u;
  logic              draw_hit, in_acc, out_load;
  logic [PROD_W-1:0] draw_prod, walk_prod;
  logic [7:0]        clip_r, clip_b;
  logic              flush_empty;
  logic [15:0]       pix;
  ucode_t            uc;

  // active size, register value limited to 1..MAX
  assign eff_w = (screen_width_r == 8'd0) ? 8'd1 :
                 (({1'b0, screen_width_r} > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : screen_width_r);
  assign eff_h = (screen_height_r == 8'd0) ? 8'd1 :
                 (({1'b0, screen_height_r} > 9'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : screen_height_r);

  assign pos_x_u  = unsigned'(in_pos_x);
  assign pos_y_u  = unsigned'(in_pos_y);
  assign draw_hit = (pos_x_u < {8'd0, eff_w}) && (pos_y_u < {8'd0, eff_h});
  assign draw_prod = PROD_W'(pos_y_u[7:0]) * PROD_W'(eff_w) + PROD_W'(pos_x_u[7:0]);
  assign walk_prod = PROD_W'(walk_row_r) * PROD_W'(eff_w) + PROD_W'(walk_col_r);

  assign clip_r      = (box_right_r < eff_w) ? box_right_r : eff_w - 8'd1;
  assign clip_b      = (box_bottom_r < eff_h) ? box_bottom_r : eff_h - 8'd1;
  assign flush_empty = (box_left_r > clip_r) || (box_top_r > clip_b);

  assign uc  = ucode_rom(phase_r);
  assign pix = clearing_r ? fill_r : to_565(rd_ok_r ? ram_rdata : 8'd0);

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    wipe_addr_nxt  = wipe_addr_r;
    box_left_nxt   = box_left_r;
    box_top_nxt    = box_top_r;
    box_right_nxt  = box_right_r;
    box_bottom_nxt = box_bottom_r;
    phase_nxt      = phase_r;
    walk_row_nxt   = walk_row_r;
    walk_col_nxt   = walk_col_r;
    low_nxt        = low_r;
    clearing_nxt   = clearing_r;
    fill_nxt       = fill_r;
    win_x0_nxt     = win_x0_r;
    win_y0_nxt     = win_y0_r;
    win_x1_nxt     = win_x1_r;
    win_y1_nxt     = win_y1_r;
    draw_addr_nxt  = draw_addr_r;
    draw_data_nxt  = draw_data_r;
    rd_addr_nxt    = rd_addr_r;
    rd_ok_nxt      = rd_ok_r;
    out_is_data_nxt = out_is_data_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = draw_addr_r;
    ram_wdata      = draw_data_r;

    case (state_r)
      ST_WIPE: begin
        ram_we        = 1'b1;
        ram_waddr     = wipe_addr_r;
        ram_wdata     = 8'd0;
        wipe_addr_nxt = wipe_addr_r + ADDR_W'(1);
        if (wipe_addr_r == ADDR_W'(STORE_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_DRAW: begin
              if (draw_hit) begin
                if (pos_x_u[7:0] < box_left_r) box_left_nxt = pos_x_u[7:0];
                if (pos_y_u[7:0] < box_top_r) box_top_nxt = pos_y_u[7:0];
                if (pos_x_u[7:0] > box_right_r) box_right_nxt = pos_x_u[7:0];
                if (pos_y_u[7:0] > box_bottom_r) box_bottom_nxt = pos_y_u[7:0];
                draw_addr_nxt = draw_prod[ADDR_W-1:0];
                draw_data_nxt = to_332(in_colour);
                state_nxt     = ST_DRAW;
              end
            end
            FUNC_FLUSH: begin
              if (phase_r == PH_IDLE && !flush_empty) begin
                win_x0_nxt     = box_left_r;
                win_y0_nxt     = box_top_r;
                win_x1_nxt     = clip_r;
                win_y1_nxt     = clip_b;
                walk_col_nxt   = box_left_r;
                walk_row_nxt   = box_top_r;
                low_nxt        = 1'b0;
                clearing_nxt   = 1'b0;
                phase_nxt      = PH_COL_CMD;
                box_left_nxt   = eff_w;
                box_top_nxt    = eff_h;
                box_right_nxt  = 8'd0;
                box_bottom_nxt = 8'd0;
              end
            end
            FUNC_CLEAR: begin
              if (phase_r == PH_IDLE) begin
                clearing_nxt  = 1'b1;
                fill_nxt      = in_colour;
                win_x0_nxt    = 8'd0;
                win_y0_nxt    = 8'd0;
                win_x1_nxt    = eff_w - 8'd1;
                win_y1_nxt    = eff_h - 8'd1;
                walk_col_nxt  = 8'd0;
                walk_row_nxt  = 8'd0;
                low_nxt       = 1'b0;
                phase_nxt     = PH_COL_CMD;
                wipe_addr_nxt = '0;
                state_nxt     = ST_WIPE;
              end
            end
            FUNC_TICK: begin
              if (phase_r != PH_IDLE) begin
                if (uc.src == SRC_PIXEL && !clearing_r) begin
                  // a pixel outside the store reads as zero
                  rd_addr_nxt = walk_prod[ADDR_W-1:0];
                  rd_ok_nxt   = (walk_prod < PROD_W'(STORE_SIZE));
                  state_nxt   = ST_READ;
                end else begin
                  state_nxt = ST_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAW: begin
        ram_we    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load        = 1'b1;
          out_is_data_nxt = uc.is_data;
          out_last_nxt    = 1'b0;
          case (uc.src)
            SRC_X0:      out_byte_nxt = win_x0_r;
            SRC_X1:      out_byte_nxt = win_x1_r;
            SRC_Y0:      out_byte_nxt = win_y0_r;
            SRC_Y1:      out_byte_nxt = win_y1_r;
            SRC_COL_CMD: out_byte_nxt = col_code_r;
            SRC_ROW_CMD: out_byte_nxt = row_code_r;
            SRC_MEM_CMD: out_byte_nxt = mem_code_r;
            SRC_PIXEL:   out_byte_nxt = low_r ? pix[7:0] : pix[15:8];
            default:     out_byte_nxt = 8'd0;
          endcase
          if (uc.pixel_step) begin
            if (!low_r) begin
              low_nxt = 1'b1;
            end else begin
              low_nxt = 1'b0;
              if (walk_col_r >= win_x1_r) begin
                walk_col_nxt = win_x0_r;
                if (walk_row_r >= win_y1_r) begin
                  out_last_nxt = 1'b1;
                  phase_nxt    = PH_IDLE;
                  clearing_nxt = 1'b0;
                end else begin
                  walk_row_nxt = walk_row_r + 8'd1;
                end
              end else begin
                walk_col_nxt = walk_col_r + 8'd1;
              end
            end
          end else begin
            phase_nxt = uc.next_step;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_WIPE;
      wipe_addr_r     <= '0;
      screen_width_r  <= 8'd128;
      screen_height_r <= 8'd160;
      col_code_r      <= 8'd42;
      row_code_r      <= 8'd43;
      mem_code_r      <= 8'd44;
      box_left_r      <= 8'd128;
      box_top_r       <= 8'd160;
      box_right_r     <= 8'd0;
      box_bottom_r    <= 8'd0;
      phase_r         <= PH_IDLE;
      walk_row_r      <= 8'd0;
      walk_col_r      <= 8'd0;
      low_r           <= 1'b0;
      clearing_r      <= 1'b0;
      fill_r          <= 16'd0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wipe_addr_r  <= wipe_addr_nxt;
      box_left_r   <= box_left_nxt;
      box_top_r    <= box_top_nxt;
      box_right_r  <= box_right_nxt;
      box_bottom_r <= box_bottom_nxt;
      phase_r      <= phase_nxt;
      walk_row_r   <= walk_row_nxt;
      walk_col_r   <= walk_col_nxt;
      low_r        <= low_nxt;
      clearing_r   <= clearing_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
          CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
          CFG_COL_CODE:      col_code_r      <= cfg_wdata;
          CFG_ROW_CODE:      row_code_r      <= cfg_wdata;
          CFG_MEM_CODE:      mem_code_r      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    win_x0_r      <= win_x0_nxt;
    win_y0_r      <= win_y0_nxt;
    win_x1_r      <= win_x1_nxt;
    win_y1_r      <= win_y1_nxt;
    draw_addr_r   <= draw_addr_nxt;
    draw_data_r   <= draw_data_nxt;
    rd_addr_r     <= rd_addr_nxt;
    rd_ok_r       <= rd_ok_nxt;
    out_is_data_r <= out_is_data_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
  end

  dwff_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (rd_addr_r),
    .rd_data (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_is_data    = out_is_data_r;
  assign out_byte_value = out_byte_r;
  assign out_last       = out_last_r;

  // the store never sees a write and a read in one cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("frame store written and read in the same cycle");

  // the final pixel byte always returns the stream to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (phase_r == PH_IDLE))
    else $error("stream still running after its last byte");

  // the pixel walk stays inside the latched window
  a_walk_win: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXELS) |-> (walk_col_r >= win_x0_r && walk_col_r <= win_x1_r &&
                                walk_row_r >= win_y0_r && walk_row_r <= win_y1_r))
    else $error("pixel walk left the window");

endmodule

### hdl/dwff_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwff_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dwff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
